/* hdl/psfc_pkg.sv */
// package: table size, frame constants, counter word, result type and controller state type
package psfc_pkg;

  // table geometry
  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  // frame qualification
  localparam logic [15:0] EthPIp          = 16'h0800;
  localparam logic [15:0] MinIpv4Frame    = 16'd34;
  localparam logic [63:0] PacketIncrement = 64'd1;

  // one counter word as stored in the count memory
  typedef struct packed {
    logic [63:0] packets;
    logic [63:0] bytes;
  } cnt_word_t;

  localparam int unsigned CntW = $bits(cnt_word_t);

  // result held in the output register
  typedef struct packed {
    logic        verdict;
    logic        counted;
    logic [63:0] packets;
    logic [63:0] bytes;
  } result_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ
  } state_e;

endpackage

/* hdl/psfc_ram.sv */
// generic single-write, single-read ram with registered read data
module psfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hdl/per_source_ip_flow_counter_unit.sv */
// top level: per-source-address packet and byte counter table
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_stall_o  frame_length_i, ether_type_i, source_address_i
//  out      output     out_valid_o/out_stall_i verdict_o, counted_o, packet_total_o,
//                                             byte_total_o
//
// a counted frame on a known address goes through accept, key match and count read,
// then write back through the count memory; every other frame ends after key match.
// keys and valid bits sit in flip-flops for the parallel match, counts in one ram.
// reset clears all valid bits at once; no clearing pass is needed.
// a stalled output holds its result; the next transfer is taken meanwhile and
// waits at the end of its lookup or count read until the output register is free.
module per_source_ip_flow_counter_unit import psfc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] frame_length_i,
  input  logic [15:0] ether_type_i,
  input  logic [31:0] source_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        verdict_o,
  output logic        counted_o,
  output logic [63:0] packet_total_o,
  output logic [63:0] byte_total_o
);

  state_e state_q, state_d;

  logic [15:0] len_q;
  logic [15:0] etype_q;
  logic [31:0] addr_q;
  logic [IdxW-1:0] slot_q, slot_d;

  logic [TableEntries-1:0] valid_q, valid_d;
  logic [31:0]             key_q [TableEntries];
  logic                    key_we;
  logic [IdxW-1:0]         key_waddr;

  result_t result_q, result_d;
  logic    out_valid_q, out_valid_d;
  logic    out_load;
  logic    out_free;

  logic            qualify;
  logic            hit;
  logic [IdxW-1:0] hit_idx;
  logic            has_free;
  logic [IdxW-1:0] free_idx;

  logic            ram_wr_en;
  logic [IdxW-1:0] ram_wr_addr;
  cnt_word_t       ram_wr_data;
  logic            ram_rd_en;
  logic [IdxW-1:0] ram_rd_addr;
  logic [CntW-1:0] ram_rd_raw;
  cnt_word_t       ram_rd_data;
  cnt_word_t       cnt_next;

  logic in_xfer;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // count memory
  psfc_ram #(
    .Width (CntW),
    .Depth (TableEntries)
  ) u_cnt_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_raw)
  );

  assign ram_rd_data = cnt_word_t'(ram_rd_raw);

  // frame qualification on the captured summary
  assign qualify = (len_q >= MinIpv4Frame) && (etype_q == EthPIp);

  // parallel key match, first hit and lowest free entry
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    has_free = 1'b0;
    free_idx = '0;
    for (int i = 0; i < TableEntries; i++) begin
      if (valid_q[i]) begin
        if (!hit && (key_q[i] == addr_q)) begin
          hit     = 1'b1;
          hit_idx = IdxW'(i);
        end
      end else if (!has_free) begin
        has_free = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  // incremented counts for a hit
  always_comb begin
    cnt_next.packets = ram_rd_data.packets + PacketIncrement;
    cnt_next.bytes   = ram_rd_data.bytes + {48'd0, len_q};
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    valid_d     = valid_q;
    key_we      = 1'b0;
    key_waddr   = free_idx;
    ram_wr_en   = 1'b0;
    ram_wr_addr = free_idx;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = hit_idx;
    out_load    = 1'b0;
    result_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (qualify && hit) begin
          ram_rd_en = 1'b1;
          slot_d    = hit_idx;
          state_d   = S_READ;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (!qualify) begin
            result_d = '0;
          end else if (has_free) begin
            // allocate with counts of one frame
            valid_d[free_idx]   = 1'b1;
            key_we              = 1'b1;
            ram_wr_en           = 1'b1;
            ram_wr_data.packets = PacketIncrement;
            ram_wr_data.bytes   = {48'd0, len_q};
            result_d.counted    = 1'b1;
            result_d.packets    = PacketIncrement;
            result_d.bytes      = {48'd0, len_q};
          end else begin
            result_d.verdict = 1'b1;
          end
        end
      end
      S_READ: begin
        ram_wr_addr = slot_q;
        if (out_free) begin
          ram_wr_en        = 1'b1;
          ram_wr_data      = cnt_next;
          out_load         = 1'b1;
          result_d.counted = 1'b1;
          result_d.packets = cnt_next.packets;
          result_d.bytes   = cnt_next.bytes;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // captured summary and hit slot
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      len_q   <= frame_length_i;
      etype_q <= ether_type_i;
      addr_q  <= source_address_i;
    end
    slot_q <= slot_d;
  end

  // key store
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[key_waddr] <= addr_q;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = result_q.verdict;
  assign counted_o      = result_q.counted;
  assign packet_total_o = result_q.packets;
  assign byte_total_o   = result_q.bytes;

  // a transfer always moves the controller into lookup
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == S_LOOKUP))
    else $error("accepted transfer did not start a lookup");

  // an abort never counts
  a_abort_uncounted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(verdict_o && counted_o))
    else $error("result both aborted and counted");

  // uncounted results carry zero totals
  a_uncounted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !counted_o) |-> ((packet_total_o == 64'd0) && (byte_total_o == 64'd0)))
    else $error("uncounted result with nonzero totals");

  // entries are never evicted
  a_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((valid_q & $past(valid_q)) == $past(valid_q)))
    else $error("table entry lost its valid bit");

  // allocation only takes an entry that was free
  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |-> !valid_q[free_idx])
    else $error("allocation hit an occupied entry");

endmodule
